// ----- rtl/radix_literal_to_integer_unit_assert.svh -----
// ----------------------------------------------------------------------------
// radix literal to integer unit - assertion macros
// concurrent property wrappers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef RADIX_LITERAL_TO_INTEGER_UNIT_ASSERT_SVH
`define RADIX_LITERAL_TO_INTEGER_UNIT_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define RLTI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlti assertion failed");
// next-cycle implication
`define RLTI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlti assertion failed");
`else
`define RLTI_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RLTI_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/rlti_pkg.sv -----
// ----------------------------------------------------------------------------
// rlti_pkg
// shared types and constants of the radix literal to integer unit
// ----------------------------------------------------------------------------
package rlti_pkg;

    localparam int VALUE_WIDTH = 64;
    // value * 16 + 8-bit digit fits in VALUE_WIDTH + 5 bits
    localparam int SUM_WIDTH   = VALUE_WIDTH + 5;
    localparam int CHAR_WIDTH  = 8;

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [SUM_WIDTH-1:0]   sum_t;
    typedef logic [CHAR_WIDTH-1:0]  char_t;

    typedef enum logic [1:0] {
        MODE_BIN = 2'd0,
        MODE_OCT = 2'd1,
        MODE_DEC = 2'd2,
        MODE_HEX = 2'd3
    } radix_mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_PREFIX   = 2'd2,
        ST_HEX      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SIGN_NONE = 2'b00,
        SIGN_POS  = 2'b01,
        SIGN_NEG  = 2'b11
    } sign_t;

    localparam radix_mode_t MODE_RESET = MODE_DEC;

    localparam char_t CH_ZERO  = 8'h30;
    localparam char_t CH_NINE  = 8'h39;
    localparam char_t CH_LA    = 8'h61;
    localparam char_t CH_LF    = 8'h66;
    localparam char_t CH_UA    = 8'h41;
    localparam char_t CH_UF    = 8'h46;
    localparam char_t CH_MINUS = 8'h2d;
    localparam char_t CH_PLUS  = 8'h2b;
    localparam char_t HEX_TEN  = 8'd10;

    // prefix characters still to drop after the first one
    localparam logic [1:0] SKIP_NONE = 2'd0;
    localparam logic [1:0] SKIP_ZERO = 2'd1;
    localparam logic [1:0] SKIP_SIGN = 2'd2;

endpackage

// ----- rtl/rlti_char_if.sv -----
// ----------------------------------------------------------------------------
// rlti_char_if
// character channel: one ascii character per beat plus end marker
// ----------------------------------------------------------------------------
interface rlti_char_if;
    import rlti_pkg::*;

    logic  valid;
    logic  ready;
    char_t char_code;
    logic  last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ----- rtl/rlti_result_if.sv -----
// ----------------------------------------------------------------------------
// rlti_result_if
// result channel: sign, magnitude and status of one literal per beat
// ----------------------------------------------------------------------------
interface rlti_result_if;
    import rlti_pkg::*;

    logic              valid;
    logic              ready;
    logic signed [1:0] sign_code;
    value_t            magnitude;
    logic [1:0]        status;

    modport source (output valid, output sign_code, output magnitude, output status,
                    input ready);
    modport sink   (input valid, input sign_code, input magnitude, input status,
                    output ready);
endinterface

// ----- rtl/radix_literal_to_integer_unit.sv -----
// ----------------------------------------------------------------------------
// radix_literal_to_integer_unit
// converts an ascii numeric literal (bin/oct/dec/hex) to sign, magnitude, status
// ----------------------------------------------------------------------------
//  channel     dir  beat                              payload
//  char_in     in   one character of a literal        char_code[7:0], last_char
//  result_out  out  one converted literal             sign_code[1:0], magnitude, status
//  cfg_write   in   radix mode write (no handshake)   cfg_write_data[1:0]
//
//  one character per cycle sustained unless a last character waits on a full result;
//  the last character passes through the input register into the result register,
//  which drives the result beat; acc * radix + digit (shift-adds) sets the cycle
//  reset clears the literal state and sets the radix mode to decimal
//  result_out stall holds only a last character in the input register; other
//  characters keep flowing into the accumulator while a result waits
// ----------------------------------------------------------------------------
`include "radix_literal_to_integer_unit_assert.svh"

module radix_literal_to_integer_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    rlti_char_if.sink            char_in,
    rlti_result_if.source        result_out,
    input  logic                 cfg_write_en,
    input  logic [1:0]           cfg_write_data
);
    import rlti_pkg::*;

    // configuration
    radix_mode_t mode_reg;

    // input register
    logic        s1_valid_reg;
    logic        s1_valid_next;
    char_t       s1_char_reg;
    logic        s1_last_reg;
    logic        s1_fire;

    // literal state
    value_t      acc_reg,    acc_next;
    logic [1:0]  skip_reg,   skip_next;
    logic        first_reg,  first_next;
    sign_t       sign_reg,   sign_next;
    status_t     status_reg, status_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    sign_t       out_sign_reg;
    value_t      out_mag_reg;
    status_t     out_status_reg;
    logic        out_free;

    // per-character step
    char_t       digit;
    logic        hex_bad;
    logic        is_dec_digit;
    sum_t        scaled;
    sum_t        sum;
    logic        ovf;
    value_t      acc_step;
    logic [1:0]  skip_step;
    sign_t       sign_step;
    status_t     status_step;
    status_t     status_fin;
    logic        do_digit;

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    // result register is free when empty or being drained this cycle
    assign out_free      = !out_valid_reg || result_out.ready;
    // non-last characters never need the result register
    assign s1_fire       = s1_valid_reg && (!s1_last_reg || out_free);
    assign char_in.ready = !s1_valid_reg || s1_fire;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (char_in.ready)
        begin
            s1_valid_next = char_in.valid;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !result_out.ready;
        if (s1_fire && s1_last_reg)
        begin
            out_valid_next = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // digit decode
    // ------------------------------------------------------------------
    assign is_dec_digit = (s1_char_reg >= CH_ZERO) && (s1_char_reg <= CH_NINE);

    always_comb
    begin
        hex_bad = 1'b0;
        digit   = s1_char_reg - CH_ZERO;   // wraps modulo 256 outside hex mode
        if (mode_reg == MODE_HEX)
        begin
            priority if (is_dec_digit)
            begin
                digit = s1_char_reg - CH_ZERO;
            end
            else if ((s1_char_reg >= CH_LA) && (s1_char_reg <= CH_LF))
            begin
                digit = s1_char_reg - CH_LA + HEX_TEN;
            end
            else if ((s1_char_reg >= CH_UA) && (s1_char_reg <= CH_UF))
            begin
                digit = s1_char_reg - CH_UA + HEX_TEN;
            end
            else
            begin
                hex_bad = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // multiply by radix with shifts, add digit, carry-out means overflow
    // ------------------------------------------------------------------
    always_comb
    begin
        unique case (mode_reg)
            MODE_BIN: scaled = SUM_WIDTH'(acc_reg) << 1;
            MODE_OCT: scaled = SUM_WIDTH'(acc_reg) << 3;
            MODE_DEC: scaled = (SUM_WIDTH'(acc_reg) << 3) + (SUM_WIDTH'(acc_reg) << 1);
            MODE_HEX: scaled = SUM_WIDTH'(acc_reg) << 4;
            default:  scaled = '0;
        endcase
    end

    assign sum      = scaled + SUM_WIDTH'(digit);
    assign ovf      = |sum[SUM_WIDTH-1:VALUE_WIDTH];

    // ------------------------------------------------------------------
    // literal state step
    // ------------------------------------------------------------------
    // a digit is taken as the leading decimal digit or after the prefix,
    // and only while no error is held
    assign do_digit = first_reg ? ((mode_reg == MODE_DEC) && is_dec_digit)
                                : ((skip_reg == SKIP_NONE) && (status_reg == ST_OK));

    always_comb
    begin
        acc_step    = acc_reg;
        skip_step   = skip_reg;
        sign_step   = sign_reg;
        status_step = status_reg;
        if (first_reg)
        begin
            sign_step = SIGN_NONE;
            priority if ((s1_char_reg == CH_MINUS) || (s1_char_reg == CH_PLUS))
            begin
                sign_step = (s1_char_reg == CH_MINUS) ? SIGN_NEG : SIGN_POS;
                skip_step = (mode_reg == MODE_DEC) ? SKIP_NONE : SKIP_SIGN;
            end
            else if ((mode_reg != MODE_DEC) && (s1_char_reg == CH_ZERO))
            begin
                skip_step = SKIP_ZERO;
            end
            else if (!do_digit)
            begin
                status_step = ST_PREFIX;
            end
            else
            begin
                // leading decimal digit, accumulated below
            end
        end
        else if (skip_reg != SKIP_NONE)
        begin
            skip_step = skip_reg - 2'd1;
        end

        if (do_digit)
        begin
            if (hex_bad)
            begin
                status_step = ST_HEX;
            end
            else
            begin
                acc_step = sum[VALUE_WIDTH-1:0];
                if (ovf)
                begin
                    status_step = ST_OVERFLOW;
                end
            end
        end
    end

    // literal ending inside its prefix is a bad prefix unless an error is held
    assign status_fin = ((skip_step != SKIP_NONE) && (status_step == ST_OK))
                        ? ST_PREFIX : status_step;

    always_comb
    begin
        acc_next    = acc_reg;
        skip_next   = skip_reg;
        first_next  = first_reg;
        sign_next   = sign_reg;
        status_next = status_reg;
        if (s1_fire)
        begin
            if (s1_last_reg)
            begin
                acc_next    = '0;
                skip_next   = SKIP_NONE;
                first_next  = 1'b1;
                sign_next   = SIGN_NONE;
                status_next = ST_OK;
            end
            else
            begin
                acc_next    = acc_step;
                skip_next   = skip_step;
                first_next  = 1'b0;
                sign_next   = sign_step;
                status_next = status_step;
            end
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            skip_reg      <= SKIP_NONE;
            first_reg     <= 1'b1;
            sign_reg      <= SIGN_NONE;
            status_reg    <= ST_OK;
        end
        else
        begin
            if (cfg_write_en)
            begin
                mode_reg <= radix_mode_t'(cfg_write_data);
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
            skip_reg      <= skip_next;
            first_reg     <= first_next;
            sign_reg      <= sign_next;
            status_reg    <= status_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (char_in.ready && char_in.valid)
        begin
            s1_char_reg <= char_in.char_code;
            s1_last_reg <= char_in.last_char;
        end
        if (s1_fire && s1_last_reg)
        begin
            out_sign_reg   <= sign_step;
            out_status_reg <= status_fin;
            out_mag_reg    <= (status_fin == ST_OK) ? acc_step : '0;
        end
    end

    assign result_out.valid     = out_valid_reg;
    assign result_out.sign_code = $signed(out_sign_reg);
    assign result_out.magnitude = out_mag_reg;
    assign result_out.status    = out_status_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // magnitude is forced to zero whenever an error is reported
    `RLTI_ASSERT_IMP(a_err_mag_zero, clk, rst_n,
        out_valid_reg && (out_status_reg != ST_OK), out_mag_reg == '0)
    // a finished literal leaves the state cleared for the next one
    `RLTI_ASSERT_NXT(a_clear_after_last, clk, rst_n,
        s1_fire && s1_last_reg,
        first_reg && (acc_reg == '0) && (status_reg == ST_OK) && (skip_reg == SKIP_NONE))
    // the input register stalls only on a last character behind a full result
    `RLTI_ASSERT_IMP(a_stall_cause, clk, rst_n,
        s1_valid_reg && !s1_fire,
        s1_last_reg && out_valid_reg && !result_out.ready)

endmodule
